FILE: rtl/atanh_series_sum_top_defines.svh
// Assertion macros for the atanh series block.
`ifndef ATANH_SERIES_SUM_TOP_DEFINES_SVH
`define ATANH_SERIES_SUM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a consequence in the same cycle.
`define ATSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atss assertion failed");
// Check a consequence in the next cycle.
`define ATSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atss assertion failed");
`else
`define ATSS_ASSERT_SAME(label, clk, rst, ante, cons)
`define ATSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/atss_pkg.sv
// Shared types and constants of the atanh series block.
`default_nettype none
package atss_pkg;

   // Configuration register indexes
   localparam logic CSR_STOP_THRESHOLD = 1'b0;
   localparam logic CSR_TERM_LIMIT     = 1'b1;

   localparam logic [30:0] STOP_THRESHOLD_RESET = 31'd2147;
   localparam logic [15:0] TERM_LIMIT_RESET     = 16'd1000;

   // Divider widths: dividend is q * (2n-1) + n, divisor is 2n+1
   localparam int DIV_W   = 49;
   localparam int DEN_W   = 17;
   localparam int DCNT_W  = $clog2(DIV_W + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_MUL,
      ST_SQ_RES,
      ST_ADD,
      ST_CHECK,
      ST_Q_MUL,
      ST_Q_RES,
      ST_N_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

FILE: rtl/atss_mul.sv
// Shared registered 32x32 unsigned multiplier.
`default_nettype none
module atss_mul (
   input  wire logic        clock,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [63:0] prod
);
   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   // Form the product, register it for the next state
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

FILE: rtl/atss_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module atss_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [atss_pkg::DIV_W-1:0]  dividend,
   input  wire logic [atss_pkg::DEN_W-1:0]  divisor,
   output atss_pkg::div_status_type         status,
   output logic      [31:0]                 quotient
);
   import atss_pkg::*;

   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    rem_sh;
   logic              fits;

   // Shift in the next dividend bit and try the subtract
   assign rem_sh = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = DCNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dvd_ff[31:0];
endmodule
`default_nettype wire

FILE: rtl/atanh_series_sum_top.sv
// Top level: atanh(x) Taylor series summed on a shared multiplier and divider.
//
//  channel | dir | signals                               | content
//  req     | in  | req_tvalid/tready/tdata[31:0]         | x_value
//  rsp     | out | rsp_tvalid/tready/tdata[63:0]/tuser   | series_sum, term_count, limit_hit
//  csr     | in  | csr_wen/csr_index/csr_wdata[30:0]     | stop_threshold, term_limit
//
// Each added term runs two passes through the shared multiplier and a bit-serial divide.
// req_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next request is taken while it is still unread.
// Reset is synchronous: sequencer idle, no result pending, config registers to defaults.
`default_nettype none
`include "atanh_series_sum_top_defines.svh"
module atanh_series_sum_top #(
   parameter int FRAC_BITS = 31
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] x_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [63:0] rsp_tdata,   // [47:0] series_sum, [63:48] term_count
   output logic             rsp_tuser,   // [0] limit_hit
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic [30:0] csr_wdata
);
   import atss_pkg::*;

   localparam int SHL = (FRAC_BITS >= 31) ? (FRAC_BITS - 31) : 0;
   localparam int SHR = (FRAC_BITS < 31) ? (31 - FRAC_BITS) : 0;
   localparam logic [48:0] RND = (49'd1 << SHR) >> 1;
   localparam logic signed [49:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] SUM_MIN = -SUM_MAX - 50'sd1;

   state_type state_ff, state_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic [31:0] x2_ff, x2_in;
   logic [31:0] q_ff, q_in;
   logic [15:0] n_ff, n_in;
   logic [47:0] sum_ff, sum_in;
   logic        flag_ff, flag_in;
   logic [30:0] eps_ff;
   logic [15:0] limit_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_sum_ff, rsp_sum_in;
   logic [15:0] rsp_count_ff, rsp_count_in;
   logic        rsp_flag_ff, rsp_flag_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] p_rnd;
   logic [16:0] num;
   logic [16:0] den;
   logic        div_start;
   logic [48:0] div_dvd;
   div_status_type div_status;
   logic [31:0] div_quot;

   logic [48:0]        aligned;
   logic signed [49:0] term_s;
   logic signed [49:0] sum_ext;

   // Odd factors of the current term
   assign num = {n_ff, 1'b0} - 17'd1;
   assign den = {n_ff, 1'b1};
   assign p_rnd = mul_p + 64'h4000_0000;
   assign div_dvd = mul_p[48:0] + {33'd0, n_ff};

   // Steer the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_Q_MUL: begin
            mul_a = mag_ff;
            mul_b = x2_ff;
         end
         ST_N_MUL: begin
            mul_a = q_ff;
            mul_b = {15'd0, num};
         end
         default: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
      endcase
   end

   atss_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   atss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (den),
      .status   (div_status),
      .quotient (div_quot)
   );

   // Align the term to the sum's fraction bits and add with saturation
   assign aligned = ((({17'd0, mag_ff}) + RND) << SHL) >> SHR;
   assign term_s  = neg_ff ? -$signed({1'b0, aligned}) : $signed({1'b0, aligned});
   assign sum_ext = $signed({{2{sum_ff[47]}}, sum_ff}) + term_s;

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      x2_in        = x2_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_count_in = rsp_count_ff;
      rsp_flag_in  = rsp_flag_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               neg_in   = req_tdata[31];
               mag_in   = req_tdata[31] ? (32'd0 - req_tdata) : req_tdata;
               n_in     = '0;
               sum_in   = '0;
               flag_in  = 1'b0;
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: state_in = ST_SQ_RES;
         ST_SQ_RES: begin
            // Round x^2 and clamp at just under one
            x2_in    = p_rnd[63:62] != 2'b00 ? 32'h7FFF_FFFF : {1'b0, p_rnd[61:31]};
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (sum_ext > SUM_MAX) begin
               sum_in  = SUM_MAX[47:0];
               flag_in = 1'b1;
            end else if (sum_ext < SUM_MIN) begin
               sum_in  = SUM_MIN[47:0];
               flag_in = 1'b1;
            end else begin
               sum_in = sum_ext[47:0];
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (mag_ff < {1'b0, eps_ff}) begin
               state_in = ST_FINISH;
            end else if (n_ff >= limit_ff) begin
               flag_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               n_in     = n_ff + 16'd1;
               state_in = ST_Q_MUL;
            end
         end
         ST_Q_MUL: state_in = ST_Q_RES;
         ST_Q_RES: begin
            q_in     = p_rnd[62:31];
            state_in = ST_N_MUL;
         end
         ST_N_MUL: state_in = ST_DIV_GO;
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               mag_in   = div_quot;
               state_in = ST_ADD;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = sum_ff;
               rsp_count_in = n_ff;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      x2_ff        <= x2_in;
      q_ff         <= q_in;
      n_ff         <= n_in;
      sum_ff       <= sum_in;
      flag_ff      <= flag_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_count_ff <= rsp_count_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff   <= STOP_THRESHOLD_RESET;
         limit_ff <= TERM_LIMIT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_STOP_THRESHOLD: eps_ff   <= csr_wdata;
            CSR_TERM_LIMIT:     limit_ff <= csr_wdata[15:0];
            default:            eps_ff   <= eps_ff;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_sum_ff};
   assign rsp_tuser  = rsp_flag_ff;

   `ATSS_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == ST_SQ_MUL)
   `ATSS_ASSERT_SAME(a_div_idle_on_start, clock, reset, div_start, !div_status.busy)
   `ATSS_ASSERT_SAME(a_count_in_limit, clock, reset, state_ff == ST_FINISH, n_ff <= limit_ff)
   `ATSS_ASSERT_SAME(a_term_bounded, clock, reset, state_ff == ST_CHECK, mag_ff <= 32'h8000_0000)
endmodule
`default_nettype wire

FILE: tb/sv/tb_atanh_series_sum_top.sv
// Testbench for the atanh series block: self-checking scoreboard with random stream stalls.
`timescale 1ns / 1ps

module tb_atanh_series_sum_top;

   localparam int TERM_FRAC = 31;
   localparam int SUM_FRAC  = 31;
   localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam logic [30:0] EPS_MAX = 31'h7FFF_FFFF;

   typedef struct {
      logic [47:0] sum;
      logic [15:0] count;
      logic        hit;
   } series_result_type;

   // Predict the series sum per request and match it against responses
   class series_scoreboard;
      bit [30:0]         stop_eps;
      bit [15:0]         max_terms;
      longint            last_term;
      longint            last_sum;
      bit [15:0]         last_index;
      bit [31:0]         last_square;
      series_result_type pending_sums[$];
      int                mismatches;

      function new();
         stop_eps    = atss_pkg::STOP_THRESHOLD_RESET;
         max_terms   = atss_pkg::TERM_LIMIT_RESET;
         last_term   = 0;
         last_sum    = 0;
         last_index  = 0;
         last_square = 0;
         mismatches  = 0;
      endfunction

      function void apply_csr(logic idx, logic [30:0] value);
         case (idx)
            atss_pkg::CSR_STOP_THRESHOLD: stop_eps = value;
            atss_pkg::CSR_TERM_LIMIT:     max_terms = value[15:0];
         endcase
      endfunction

      // Scale a Q1.31 magnitude to the sum's fraction width, round half up
      function longint aligned_term(bit neg, longint unsigned mag);
         int sh = TERM_FRAC - SUM_FRAC;
         longint unsigned r;
         if (sh <= 0) begin
            r = mag << (-sh);
         end else begin
            r = (mag + (64'd1 << (sh - 1))) >> sh;
         end
         return neg ? -longint'(r) : longint'(r);
      endfunction

      function longint sat_sum(longint acc, longint t, inout bit hit);
         longint r;
         r = acc + t;
         if (r > SUM_MAX) begin
            hit = 1'b1;
            return SUM_MAX;
         end
         if (r < SUM_MIN) begin
            hit = 1'b1;
            return SUM_MIN;
         end
         return r;
      endfunction

      // Sum the series for one accepted argument and queue the result
      function void take_argument(logic [31:0] x);
         bit                neg;
         longint unsigned   mag;
         longint unsigned   x2;
         longint unsigned   q;
         longint unsigned   num;
         longint unsigned   den;
         longint            s;
         bit                hit;
         int unsigned       n;
         series_result_type r;
         neg = x[31];
         mag = neg ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
         x2 = (mag * mag + (64'd1 << 30)) >> 31;
         if (x2 > 64'h7FFF_FFFF) x2 = 64'h7FFF_FFFF;
         hit = 1'b0;
         n = 0;
         s = sat_sum(0, aligned_term(neg, mag), hit);
         while (mag >= {33'd0, stop_eps}) begin
            if (n >= max_terms) begin
               hit = 1'b1;
               break;
            end
            n++;
            q   = (mag * x2 + (64'd1 << 30)) >> 31;
            num = 64'(2 * n - 1);
            den = 64'(2 * n + 1);
            mag = (q * num + den / 2) / den;
            s   = sat_sum(s, aligned_term(neg, mag), hit);
         end
         last_term   = neg ? -longint'(mag) : longint'(mag);
         last_sum    = s;
         last_index  = n[15:0];
         last_square = x2[31:0];
         r.sum   = s[47:0];
         r.count = n[15:0];
         r.hit   = hit;
         pending_sums.push_back(r);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
         mismatches++;
      endtask

      // Compare one response with the oldest queued sum
      task check_sum(logic [63:0] data, logic user);
         series_result_type e;
         if (pending_sums.size() == 0) begin
            report_mismatch("response with no request pending", data, 64'd0);
            return;
         end
         e = pending_sums.pop_front();
         if (data[47:0] !== e.sum) begin
            report_mismatch("series_sum", {16'd0, data[47:0]}, {16'd0, e.sum});
         end
         if (data[63:48] !== e.count) begin
            report_mismatch("term_count", {48'd0, data[63:48]}, {48'd0, e.count});
         end
         if (user !== e.hit) report_mismatch("limit_hit", {63'd0, user}, {63'd0, e.hit});
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] x_value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [47:0] series_sum, [63:48] term_count
   logic        rsp_tuser;   // [0] limit_hit
   logic        csr_wen;
   logic        csr_index;
   logic [30:0] csr_wdata;

   series_scoreboard sb = new();
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   atanh_series_sum_top #(.FRAC_BITS(SUM_FRAC)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Write one register; the block must be idle
   task automatic write_csr(logic idx, logic [30:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.apply_csr(idx, value);
   endtask

   // Send one request; hold valid high across back-to-back requests
   task automatic send_request(logic [31:0] x);
      int gap;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.take_argument(x);
   endtask

   // Drop valid and wait until every queued sum has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending_sums.size() != 0) @(posedge clock);
   endtask

   // Accept responses; a stall starts once a response is waiting
   task automatic take_responses();
      int stall;
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (rsp_tvalid !== 1'b1);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_sum(rsp_tdata, rsp_tuser);
      end
   endtask

   initial begin
      logic [31:0] corner_args [11];
      logic [31:0] x;
      logic [31:0] upper_bits;
      logic [30:0] eps;
      logic [15:0] terms;
      int          kind;
      corner_args = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h4000_0000, 32'hC000_0000, 32'h6000_0000,
                      32'h0000_0863, 32'h0000_0862, 32'hFFFF_F79D};
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = atss_pkg::CSR_STOP_THRESHOLD;
      csr_wdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      fork
         take_responses();
      join_none

      // Corner arguments at reset settings: zero, one lsb, minus one, near one,
      // threshold edges
      foreach (corner_args[i]) send_request(corner_args[i]);
      settle();

      // Zero threshold: loop runs to the term limit
      write_csr(atss_pkg::CSR_STOP_THRESHOLD, 31'd0);
      write_csr(atss_pkg::CSR_TERM_LIMIT, 31'd3);
      send_request(32'h4000_0000);
      send_request(32'h0000_0001);
      send_request(32'h8000_0000);
      settle();

      // Largest threshold: only magnitudes at or above it iterate
      write_csr(atss_pkg::CSR_STOP_THRESHOLD, EPS_MAX);
      write_csr(atss_pkg::CSR_TERM_LIMIT, 31'd2);
      send_request(32'h8000_0000);
      send_request(32'h7FFF_FFFF);
      send_request(32'h4000_0000);
      settle();

      // Term limit of zero: no terms beyond x itself are added
      write_csr(atss_pkg::CSR_STOP_THRESHOLD, 31'd1000);
      write_csr(atss_pkg::CSR_TERM_LIMIT, 31'd0);
      send_request(32'h7FFF_FFFF);
      send_request(32'h0000_0100);
      settle();

      // Random phases, each with its own register settings
      for (int p = 0; p < 10; p++) begin
         kind = p % 6;
         upper_bits = $urandom();
         case (kind)
            0: begin
               eps   = 31'($urandom_range(0, EPS_MAX));
               terms = 16'($urandom_range(1, 16));
            end
            1: begin
               eps   = 31'd0;
               terms = 16'($urandom_range(1, 8));
            end
            2: begin
               eps   = EPS_MAX;
               terms = 16'($urandom_range(1, 16));
            end
            3: begin
               eps   = 31'($urandom_range(2147, EPS_MAX));
               terms = 16'hFFFF;
            end
            4: begin
               eps   = 31'($urandom_range(0, 4095));
               terms = 16'($urandom_range(1, 16));
            end
            default: begin
               eps   = 31'($urandom_range(0, EPS_MAX));
               terms = 16'd0;
            end
         endcase
         write_csr(atss_pkg::CSR_STOP_THRESHOLD, eps);
         write_csr(atss_pkg::CSR_TERM_LIMIT, {upper_bits[14:0], terms});
         repeat (115) begin
            x = $urandom();
            // keep arguments within one half under the full term limit
            if (kind == 3) x = $signed(x) >>> 1;
            send_request(x);
         end
         settle();
      end

      repeat (100) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Bound the run well past the slowest correct one
   initial begin
      #(80_000_000);
      $display("status: fail");
      $finish;
   end

endmodule
